// ----- hw/rtl/assert_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros
// Shared forms for the concurrent assertions of the Poly1305 block.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked at every rising edge out of reset.
`define P1305_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked at every rising edge out of reset.
`define P1305_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hw/rtl/poly1305_pkg.sv -----
// ----------------------------------------------------------------------------
// Poly1305 package
// Widths, register codes, sequencer states and the multiply unit's control.
// ----------------------------------------------------------------------------
package poly1305_pkg;

    // Field widths of the channels and the configuration port.
    localparam int WORD_W    = 64;
    localparam int CNT_W     = 5;
    localparam int CFG_IDX_W = 2;
    localparam int BLK_BYTES = 16;

    // Limb arithmetic. The accumulator is five limbs in radix 2^26.
    localparam int NLIMB   = 5;
    localparam int LIMB_W  = 26;
    localparam int ACC_W   = 27;
    localparam int OPA_W   = 28;
    localparam int OPB_W   = 29;
    localparam int PROD_W  = OPA_W + OPB_W;
    localparam int DSUM_W  = 60;
    localparam int CARRY_W = 35;
    localparam int LIDX_W  = 3;

    localparam logic [LIDX_W-1:0] LAST_LIMB = LIDX_W'(NLIMB - 1);

    // Clamp masks for the limbs of r.
    localparam logic [LIMB_W-1:0] CLAMP_R1 = 26'h3ffff03;
    localparam logic [LIMB_W-1:0] CLAMP_R2 = 26'h3ffc0ff;
    localparam logic [LIMB_W-1:0] CLAMP_R3 = 26'h3f03fff;
    localparam logic [LIMB_W-1:0] CLAMP_R4 = 26'h00fffff;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_KEY_R_LO = 2'd0,
        CFG_KEY_R_HI = 2'd1,
        CFG_PAD_LO   = 2'd2,
        CFG_PAD_HI   = 2'd3
    } cfg_reg_t;

    // Sequencer states.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_DRAIN,
        ST_CARRY,
        ST_WRAP,
        ST_FIN_CARRY,
        ST_FIN_SEL,
        ST_FIN_TAG
    } state_t;

    // Request to the multiply-accumulate unit.
    typedef struct packed {
        logic              vld;
        logic              first;
        logic              last;
        logic [LIDX_W-1:0] idx;
    } mac_req_t;

    // Completion from the multiply-accumulate unit.
    typedef struct packed {
        logic              done;
        logic [LIDX_W-1:0] idx;
    } mac_rsp_t;

endpackage

// ----- hw/rtl/poly1305_msg_if.sv -----
// ----------------------------------------------------------------------------
// Poly1305 message channel
// One word is one 16-byte message block with its byte count and last flag.
// ----------------------------------------------------------------------------
interface poly1305_msg_if;
    logic                               valid;
    logic                               ready;
    logic [poly1305_pkg::WORD_W-1:0]    block_lo;
    logic [poly1305_pkg::WORD_W-1:0]    block_hi;
    logic [poly1305_pkg::CNT_W-1:0]     byte_count;
    logic                               last_block;

    modport source (
        output valid, block_lo, block_hi, byte_count, last_block,
        input  ready
    );

    modport sink (
        input  valid, block_lo, block_hi, byte_count, last_block,
        output ready
    );
endinterface

// ----- hw/rtl/poly1305_tag_if.sv -----
// ----------------------------------------------------------------------------
// Poly1305 tag channel
// One word is one 128-bit authentication tag.
// ----------------------------------------------------------------------------
interface poly1305_tag_if;
    logic                               valid;
    logic                               ready;
    logic [poly1305_pkg::WORD_W-1:0]    tag_lo;
    logic [poly1305_pkg::WORD_W-1:0]    tag_hi;

    modport source (
        output valid, tag_lo, tag_hi,
        input  ready
    );

    modport sink (
        input  valid, tag_lo, tag_hi,
        output ready
    );
endinterface

// ----- hw/rtl/poly1305_mau.sv -----
// ----------------------------------------------------------------------------
// Poly1305 multiply-accumulate unit
// One 28x29 multiplier with a registered product, followed by an accumulator
// that sums the five partial products of one output limb.
// ----------------------------------------------------------------------------
module poly1305_mau (
    input  logic                              clk,
    input  logic                              rst_n,
    input  poly1305_pkg::mac_req_t            req,
    input  logic [poly1305_pkg::OPA_W-1:0]    op_a,
    input  logic [poly1305_pkg::OPB_W-1:0]    op_b,
    output poly1305_pkg::mac_rsp_t            rsp,
    output logic [poly1305_pkg::DSUM_W-1:0]   sum
);

    logic [poly1305_pkg::PROD_W-1:0] prod_reg;
    poly1305_pkg::mac_req_t          stg_reg;
    logic [poly1305_pkg::DSUM_W-1:0] acc_reg;
    logic [poly1305_pkg::DSUM_W-1:0] acc_next;
    poly1305_pkg::mac_rsp_t          rsp_reg;

    // Product stage.
    always_ff @(posedge clk)
    begin
        prod_reg <= poly1305_pkg::PROD_W'(op_a) * poly1305_pkg::PROD_W'(op_b);
    end

    // Control travels alongside the product.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stg_reg <= '0;
            rsp_reg <= '0;
        end
        else
        begin
            stg_reg      <= req;
            rsp_reg.done <= stg_reg.vld && stg_reg.last;
            rsp_reg.idx  <= stg_reg.idx;
        end
    end

    // The first term of a limb restarts the sum.
    always_comb
    begin
        acc_next = (stg_reg.first ? '0 : acc_reg) + poly1305_pkg::DSUM_W'(prod_reg);
    end

    always_ff @(posedge clk)
    begin
        if (stg_reg.vld)
        begin
            acc_reg <= acc_next;
        end
    end

    assign rsp = rsp_reg;
    assign sum = acc_reg;

endmodule

// ----- hw/rtl/poly1305_mac.sv -----
// ----------------------------------------------------------------------------
// Poly1305 authenticator
// Top level: key registers, accumulator limbs, block sequencer and finish.
// ----------------------------------------------------------------------------
// A message block with a nonzero byte count is accepted, then the 25 partial
// products of h*r are issued through the single 28x29 multiplier and pass its
// product and accumulator registers; five carry steps and one wrap step that
// folds the top carry back times five follow. The block is not ready during
// that time. A count of zero skips the multiply. A word marked last then adds
// the finish steps (carry, final subtract, pad add) and a tag word appears on
// the tag channel; the finish waits only if the previous tag has not yet been
// taken. The user writes keys through cfg_write, cfg_index and cfg_data while
// the block is idle; the block itself does not enforce this. r is clamped as it is used.
// ----------------------------------------------------------------------------
module poly1305_mac (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_write,
    input  logic [poly1305_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [poly1305_pkg::WORD_W-1:0]      cfg_data,
    poly1305_msg_if.sink                         msg,
    poly1305_tag_if.source                       tag
);

    // Key registers.
    logic [poly1305_pkg::WORD_W-1:0] key_r_lo_reg;
    logic [poly1305_pkg::WORD_W-1:0] key_r_hi_reg;
    logic [poly1305_pkg::WORD_W-1:0] pad_lo_reg;
    logic [poly1305_pkg::WORD_W-1:0] pad_hi_reg;

    // Sequencer and datapath registers.
    poly1305_pkg::state_t             state_reg, state_next;
    logic [poly1305_pkg::ACC_W-1:0]   h_reg    [poly1305_pkg::NLIMB];
    logic [poly1305_pkg::ACC_W-1:0]   h_next   [poly1305_pkg::NLIMB];
    logic [poly1305_pkg::OPA_W-1:0]   hin_reg  [poly1305_pkg::NLIMB];
    logic [poly1305_pkg::OPA_W-1:0]   hin_next [poly1305_pkg::NLIMB];
    logic [poly1305_pkg::DSUM_W-1:0]  d_reg    [poly1305_pkg::NLIMB];
    logic                             last_reg, last_next;
    logic [poly1305_pkg::LIDX_W-1:0]  ii_reg, ii_next;
    logic [poly1305_pkg::LIDX_W-1:0]  jj_reg, jj_next;
    logic [poly1305_pkg::LIDX_W-1:0]  cidx_reg, cidx_next;
    logic [poly1305_pkg::CARRY_W-1:0] carry_reg, carry_next;
    logic                             tag_valid_reg, tag_valid_next;
    logic [poly1305_pkg::WORD_W-1:0]  tag_lo_reg, tag_lo_next;
    logic [poly1305_pkg::WORD_W-1:0]  tag_hi_reg, tag_hi_next;

    // Padded block and its limbs.
    logic [8*poly1305_pkg::BLK_BYTES-1:0] blk;
    logic [8*poly1305_pkg::BLK_BYTES-1:0] pblk;
    logic                                 full_blk;
    logic [poly1305_pkg::OPA_W-1:0]       m_limb [poly1305_pkg::NLIMB];

    // Clamped r and its multiples of five.
    logic [8*poly1305_pkg::BLK_BYTES-1:0] kr;
    logic [poly1305_pkg::LIMB_W-1:0]      r_limb [poly1305_pkg::NLIMB];
    logic [poly1305_pkg::OPB_W-1:0]       s_limb [poly1305_pkg::NLIMB];
    logic [poly1305_pkg::LIDX_W-1:0]      coef_idx;
    logic [poly1305_pkg::OPB_W-1:0]       coef;

    // Multiply unit connections.
    poly1305_pkg::mac_req_t           mac_req;
    poly1305_pkg::mac_rsp_t           mac_rsp;
    logic [poly1305_pkg::DSUM_W-1:0]  mac_sum;

    // Carry and finish temporaries.
    logic [poly1305_pkg::DSUM_W:0]    csum;
    logic [38:0]                      wrap0;
    logic [poly1305_pkg::ACC_W:0]     ft0, ft2, ft3, ft4;
    logic [poly1305_pkg::ACC_W:0]     gt0, gt1, gt2, gt3, gt4;
    logic                             g_sel;
    logic [poly1305_pkg::WORD_W-1:0]  t_lo, t_hi;
    logic [2*poly1305_pkg::WORD_W-1:0] t_sum;

    logic msg_fire;
    logic tag_fire;
    logic tag_slot;

    assign msg.ready = (state_reg == poly1305_pkg::ST_IDLE);
    assign msg_fire  = msg.valid && msg.ready;
    assign tag_fire  = tag_valid_reg && tag.ready;
    assign tag_slot  = !tag_valid_reg || tag.ready;

    // Configuration writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_r_lo_reg <= '0;
            key_r_hi_reg <= '0;
            pad_lo_reg   <= '0;
            pad_hi_reg   <= '0;
        end
        else if (cfg_write)
        begin
            case (poly1305_pkg::cfg_reg_t'(cfg_index))
                poly1305_pkg::CFG_KEY_R_LO: key_r_lo_reg <= cfg_data;
                poly1305_pkg::CFG_KEY_R_HI: key_r_hi_reg <= cfg_data;
                poly1305_pkg::CFG_PAD_LO:   pad_lo_reg   <= cfg_data;
                poly1305_pkg::CFG_PAD_HI:   pad_hi_reg   <= cfg_data;
                default: ;
            endcase
        end
    end

    // Pad the block: keep the counted bytes, put 0x01 right after them.
    always_comb
    begin
        blk      = {msg.block_hi, msg.block_lo};
        full_blk = (msg.byte_count >= poly1305_pkg::CNT_W'(poly1305_pkg::BLK_BYTES));
        for (int b = 0; b < poly1305_pkg::BLK_BYTES; b++)
        begin
            if (msg.byte_count > poly1305_pkg::CNT_W'(b))
            begin
                pblk[8*b +: 8] = blk[8*b +: 8];
            end
            else if (msg.byte_count == poly1305_pkg::CNT_W'(b))
            begin
                pblk[8*b +: 8] = 8'h01;
            end
            else
            begin
                pblk[8*b +: 8] = 8'h00;
            end
        end
        m_limb[0] = poly1305_pkg::OPA_W'(pblk[25:0]);
        m_limb[1] = poly1305_pkg::OPA_W'(pblk[51:26]);
        m_limb[2] = poly1305_pkg::OPA_W'(pblk[77:52]);
        m_limb[3] = poly1305_pkg::OPA_W'(pblk[103:78]);
        m_limb[4] = poly1305_pkg::OPA_W'({full_blk, pblk[127:104]});
    end

    // Clamp r into limbs and form 5*r for the wrapped terms.
    always_comb
    begin
        kr        = {key_r_hi_reg, key_r_lo_reg};
        r_limb[0] = kr[25:0];
        r_limb[1] = kr[51:26] & poly1305_pkg::CLAMP_R1;
        r_limb[2] = kr[77:52] & poly1305_pkg::CLAMP_R2;
        r_limb[3] = kr[103:78] & poly1305_pkg::CLAMP_R3;
        r_limb[4] = poly1305_pkg::LIMB_W'(kr[127:104]) & poly1305_pkg::CLAMP_R4;
        for (int k = 0; k < poly1305_pkg::NLIMB; k++)
        begin
            s_limb[k] = poly1305_pkg::OPB_W'(r_limb[k])
                      + (poly1305_pkg::OPB_W'(r_limb[k]) << 2);
        end
    end

    // Term (i, j) of the product uses r[i-j], or 5*r[i-j+5] when it wraps.
    always_comb
    begin
        if (ii_reg >= jj_reg)
        begin
            coef_idx = ii_reg - jj_reg;
            coef     = poly1305_pkg::OPB_W'(r_limb[coef_idx]);
        end
        else
        begin
            coef_idx = ii_reg + poly1305_pkg::LIDX_W'(poly1305_pkg::NLIMB) - jj_reg;
            coef     = s_limb[coef_idx];
        end
        mac_req.vld   = (state_reg == poly1305_pkg::ST_MUL);
        mac_req.first = (jj_reg == '0);
        mac_req.last  = (jj_reg == poly1305_pkg::LAST_LIMB);
        mac_req.idx   = ii_reg;
    end

    poly1305_mau u_mau (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (mac_req),
        .op_a  (hin_reg[jj_reg]),
        .op_b  (coef),
        .rsp   (mac_rsp),
        .sum   (mac_sum)
    );

    // Completed product limbs land here.
    always_ff @(posedge clk)
    begin
        if (mac_rsp.done)
        begin
            d_reg[mac_rsp.idx] <= mac_sum;
        end
    end

    // Carry, wrap and finish arithmetic.
    always_comb
    begin
        csum  = {1'b0, d_reg[cidx_reg]} + (poly1305_pkg::DSUM_W + 1)'(carry_reg);
        wrap0 = 39'(h_reg[0]) + 39'(carry_reg) + (39'(carry_reg) << 2);

        // Finish carry pass from limb 1 around to limb 1.
        ft2 = {1'b0, h_reg[2]} + (poly1305_pkg::ACC_W + 1)'(h_reg[1][26]);
        ft3 = {1'b0, h_reg[3]} + (poly1305_pkg::ACC_W + 1)'(ft2[27:26]);
        ft4 = {1'b0, h_reg[4]} + (poly1305_pkg::ACC_W + 1)'(ft3[27:26]);
        ft0 = {1'b0, h_reg[0]} + (poly1305_pkg::ACC_W + 1)'(ft4[27:26])
            + ((poly1305_pkg::ACC_W + 1)'(ft4[27:26]) << 2);

        // Trial subtraction of 2^130-5: add five and look at bit 130.
        gt0   = {1'b0, h_reg[0]} + 28'd5;
        gt1   = {1'b0, h_reg[1]} + (poly1305_pkg::ACC_W + 1)'(gt0[27:26]);
        gt2   = {1'b0, h_reg[2]} + (poly1305_pkg::ACC_W + 1)'(gt1[27:26]);
        gt3   = {1'b0, h_reg[3]} + (poly1305_pkg::ACC_W + 1)'(gt2[27:26]);
        gt4   = {1'b0, h_reg[4]} + (poly1305_pkg::ACC_W + 1)'(gt3[27:26]);
        g_sel = (gt4[27:26] != 2'b00);

        // Pack the limbs into 128 bits and add the pad.
        t_lo  = poly1305_pkg::WORD_W'(h_reg[0])
              | (poly1305_pkg::WORD_W'(h_reg[1]) << 26)
              | (poly1305_pkg::WORD_W'(h_reg[2]) << 52);
        t_hi  = poly1305_pkg::WORD_W'(h_reg[2] >> 12)
              | (poly1305_pkg::WORD_W'(h_reg[3]) << 14)
              | (poly1305_pkg::WORD_W'(h_reg[4]) << 40);
        t_sum = {t_hi, t_lo} + {pad_hi_reg, pad_lo_reg};
    end

    // Sequencer: next state and datapath updates.
    always_comb
    begin
        state_next     = state_reg;
        h_next         = h_reg;
        hin_next       = hin_reg;
        last_next      = last_reg;
        ii_next        = ii_reg;
        jj_next        = jj_reg;
        cidx_next      = cidx_reg;
        carry_next     = carry_reg;
        tag_valid_next = tag_fire ? 1'b0 : tag_valid_reg;
        tag_lo_next    = tag_lo_reg;
        tag_hi_next    = tag_hi_reg;

        case (state_reg)
            poly1305_pkg::ST_IDLE:
            begin
                if (msg_fire)
                begin
                    for (int j = 0; j < poly1305_pkg::NLIMB; j++)
                    begin
                        hin_next[j] = poly1305_pkg::OPA_W'(h_reg[j]) + m_limb[j];
                    end
                    last_next = msg.last_block;
                    ii_next   = '0;
                    jj_next   = '0;
                    if (msg.byte_count != '0)
                    begin
                        state_next = poly1305_pkg::ST_MUL;
                    end
                    else if (msg.last_block)
                    begin
                        state_next = poly1305_pkg::ST_FIN_CARRY;
                    end
                end
            end

            poly1305_pkg::ST_MUL:
            begin
                if (jj_reg == poly1305_pkg::LAST_LIMB)
                begin
                    jj_next = '0;
                    ii_next = ii_reg + 1'b1;
                    if (ii_reg == poly1305_pkg::LAST_LIMB)
                    begin
                        state_next = poly1305_pkg::ST_DRAIN;
                    end
                end
                else
                begin
                    jj_next = jj_reg + 1'b1;
                end
            end

            poly1305_pkg::ST_DRAIN:
            begin
                if (mac_rsp.done && (mac_rsp.idx == poly1305_pkg::LAST_LIMB))
                begin
                    cidx_next  = '0;
                    carry_next = '0;
                    state_next = poly1305_pkg::ST_CARRY;
                end
            end

            poly1305_pkg::ST_CARRY:
            begin
                h_next[cidx_reg] = poly1305_pkg::ACC_W'(csum[25:0]);
                carry_next       = csum[poly1305_pkg::DSUM_W:26];
                cidx_next        = cidx_reg + 1'b1;
                if (cidx_reg == poly1305_pkg::LAST_LIMB)
                begin
                    state_next = poly1305_pkg::ST_WRAP;
                end
            end

            poly1305_pkg::ST_WRAP:
            begin
                h_next[0]  = poly1305_pkg::ACC_W'(wrap0[25:0]);
                h_next[1]  = h_reg[1] + poly1305_pkg::ACC_W'(wrap0[38:26]);
                state_next = last_reg ? poly1305_pkg::ST_FIN_CARRY : poly1305_pkg::ST_IDLE;
            end

            poly1305_pkg::ST_FIN_CARRY:
            begin
                h_next[0]  = poly1305_pkg::ACC_W'(ft0[25:0]);
                h_next[1]  = poly1305_pkg::ACC_W'(h_reg[1][25:0])
                           + poly1305_pkg::ACC_W'(ft0[27:26]);
                h_next[2]  = poly1305_pkg::ACC_W'(ft2[25:0]);
                h_next[3]  = poly1305_pkg::ACC_W'(ft3[25:0]);
                h_next[4]  = poly1305_pkg::ACC_W'(ft4[25:0]);
                state_next = poly1305_pkg::ST_FIN_SEL;
            end

            poly1305_pkg::ST_FIN_SEL:
            begin
                if (g_sel)
                begin
                    h_next[0] = poly1305_pkg::ACC_W'(gt0[25:0]);
                    h_next[1] = poly1305_pkg::ACC_W'(gt1[25:0]);
                    h_next[2] = poly1305_pkg::ACC_W'(gt2[25:0]);
                    h_next[3] = poly1305_pkg::ACC_W'(gt3[25:0]);
                    h_next[4] = poly1305_pkg::ACC_W'(gt4 - 28'h4000000);
                end
                state_next = poly1305_pkg::ST_FIN_TAG;
            end

            poly1305_pkg::ST_FIN_TAG:
            begin
                // Wait for room in the tag register, then clear the accumulator.
                if (tag_slot)
                begin
                    tag_lo_next    = t_sum[poly1305_pkg::WORD_W-1:0];
                    tag_hi_next    = t_sum[2*poly1305_pkg::WORD_W-1:poly1305_pkg::WORD_W];
                    tag_valid_next = 1'b1;
                    for (int j = 0; j < poly1305_pkg::NLIMB; j++)
                    begin
                        h_next[j] = '0;
                    end
                    state_next = poly1305_pkg::ST_IDLE;
                end
            end

            default:
            begin
                state_next = poly1305_pkg::ST_IDLE;
            end
        endcase
    end

    // Control registers and accumulator limbs.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= poly1305_pkg::ST_IDLE;
            tag_valid_reg <= 1'b0;
            last_reg      <= 1'b0;
            ii_reg        <= '0;
            jj_reg        <= '0;
            cidx_reg      <= '0;
            for (int j = 0; j < poly1305_pkg::NLIMB; j++)
            begin
                h_reg[j] <= '0;
            end
        end
        else
        begin
            state_reg     <= state_next;
            tag_valid_reg <= tag_valid_next;
            last_reg      <= last_next;
            ii_reg        <= ii_next;
            jj_reg        <= jj_next;
            cidx_reg      <= cidx_next;
            h_reg         <= h_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        hin_reg    <= hin_next;
        carry_reg  <= carry_next;
        tag_lo_reg <= tag_lo_next;
        tag_hi_reg <= tag_hi_next;
    end

    assign tag.valid  = tag_valid_reg;
    assign tag.tag_lo = tag_lo_reg;
    assign tag.tag_hi = tag_hi_reg;

endmodule

// ----- hw/rtl/poly1305_chk.sv -----
// ----------------------------------------------------------------------------
// Poly1305 port checker
// Watches the top level's channels and checks their behavior over time.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module poly1305_chk (
    input logic                               clk,
    input logic                               rst_n,
    input logic                               msg_valid,
    input logic                               msg_ready,
    input logic [poly1305_pkg::CNT_W-1:0]     byte_count,
    input logic                               tag_valid,
    input logic                               tag_ready,
    input logic [poly1305_pkg::WORD_W-1:0]    tag_lo,
    input logic [poly1305_pkg::WORD_W-1:0]    tag_hi
);

    // A stalled tag word holds its value.
    `P1305_ASSERT_NXT(a_tag_hold, clk, rst_n, tag_valid && !tag_ready, tag_valid && $stable(tag_lo) && $stable(tag_hi), "tag word changed while stalled")

    // A block with data keeps the block busy for the multiply.
    `P1305_ASSERT_NXT(a_busy_after_block, clk, rst_n, msg_valid && msg_ready && (byte_count != '0), !msg_ready, "block ready right after a data word")

    // No tag can appear in the cycle after a word is taken.
    `P1305_ASSERT_NXT(a_no_early_tag, clk, rst_n, msg_valid && msg_ready && !tag_valid, !tag_valid, "tag appeared one cycle after a word")

    // A new tag is only produced out of the busy finish sequence.
    `P1305_ASSERT_IMP(a_tag_from_finish, clk, rst_n, $rose(tag_valid), $past(!msg_ready), "tag rose while block was idle")

endmodule

bind poly1305_mac poly1305_chk u_chk (
    .clk        (clk),
    .rst_n      (rst_n),
    .msg_valid  (msg.valid),
    .msg_ready  (msg.ready),
    .byte_count (msg.byte_count),
    .tag_valid  (tag.valid),
    .tag_ready  (tag.ready),
    .tag_lo     (tag.tag_lo),
    .tag_hi     (tag.tag_hi)
);
